// ===== rtl/core/host_request_poll_sequencer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the host request poll sequencer
// Shared wrappers for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef HOST_REQUEST_POLL_SEQUENCER_MACROS_SVH
`define HOST_REQUEST_POLL_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HRPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrps assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrps assertion failed");

`endif

// ===== rtl/core/hrps_pkg.sv =====
// ---------------------------------------------------------------------------
// hrps_pkg
// Types, codes and reset values shared by the request poll sequencer files.
// ---------------------------------------------------------------------------
package hrps_pkg;

  localparam int OP_W      = 2;
  localparam int LEN_W     = 8;
  localparam int CODE_W    = 3;
  localparam int EVENT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MS_W      = 16;

  localparam int TIMER_BITS_DEF = 16;

  localparam logic [MS_W-1:0]  REQUEST_WAIT_RST     = 16'd64;
  localparam logic [MS_W-1:0]  RESPONSE_TIMEOUT_RST = 16'd1505;
  localparam logic [MS_W-1:0]  POLL_INTERVAL_RST    = 16'd50;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST       = 8'd64;

  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 2'd0,
    OP_CONFIG_DONE = 2'd1,
    OP_COMMAND     = 2'd2
  } op_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 2'd0,
    EV_RECEIVED = 2'd1,
    EV_TIMEOUT  = 2'd2
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQUEST_WAIT     = 2'd0,
    CFG_RESPONSE_TIMEOUT = 2'd1,
    CFG_POLL_INTERVAL    = 2'd2,
    CFG_MAX_LENGTH       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0]  fsm_code;
    logic               request_line_low;
    logic               configure_strobe;
    logic               send_strobe;
    logic               poll_strobe;
    logic [EVENT_W-1:0] event_code;
    logic               overflow;
    logic [LEN_W-1:0]   response_length;
  } result_t;

endpackage

// ===== rtl/core/hrps_in_if.sv =====
// ---------------------------------------------------------------------------
// hrps_in_if
// Input channel of the sequencer: one operation and the client reply byte.
// ---------------------------------------------------------------------------
interface hrps_in_if import hrps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [LEN_W-1:0] reply_length;

  modport source (output valid, operation, reply_length, input ready);
  modport sink (input valid, operation, reply_length, output ready);
endinterface

// ===== rtl/core/hrps_out_if.sv =====
// ---------------------------------------------------------------------------
// hrps_out_if
// Result channel of the sequencer: state code, strobes and response event.
// ---------------------------------------------------------------------------
interface hrps_out_if import hrps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  fsm_code;
  logic               request_line_low;
  logic               configure_strobe;
  logic               send_strobe;
  logic               poll_strobe;
  logic [EVENT_W-1:0] event_code;
  logic               overflow;
  logic [LEN_W-1:0]   response_length;

  modport source (output valid, fsm_code, request_line_low, configure_strobe, send_strobe,
                  poll_strobe, event_code, overflow, response_length, input ready);
  modport sink (input valid, fsm_code, request_line_low, configure_strobe, send_strobe,
                poll_strobe, event_code, overflow, response_length, output ready);
endinterface

// ===== rtl/core/host_request_poll_sequencer.sv =====
// ---------------------------------------------------------------------------
// host_request_poll_sequencer
// Each result is registered. Throughput: one transfer per cycle while the
// output is free; the state update is a single pass of compare
// logic between the sequencer registers and the result register.
// Reset (synchronous, rst_n low): sequencer idle, timers and latched events
// cleared, configuration registers back to their defaults, output empty.
// ---------------------------------------------------------------------------
`include "host_request_poll_sequencer_macros.svh"

module host_request_poll_sequencer import hrps_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hrps_in_if.sink               in_ch,
  hrps_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Compare width covers both the timers and the 16-bit thresholds.
  localparam int CW = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;
  localparam logic [TIMER_BITS-1:0] TMAX   = {TIMER_BITS{1'b1}};
  localparam logic [CW-1:0]         TMAX_W = CW'(TMAX);

  typedef enum logic [CODE_W-1:0] {
    ST_WAIT_CFG    = 3'd0,
    ST_IDLE        = 3'd1,
    ST_WAIT_CLIENT = 3'd2,
    ST_WAIT_RESP   = 3'd3,
    ST_FINISH      = 3'd4
  } state_t;

  logic [MS_W-1:0]  req_wait_r, timeout_r, poll_int_r;
  logic [LEN_W-1:0] max_len_r;

  state_t                state_r, state_nxt;
  logic                  cfg_done_r, cfg_done_nxt;
  logic                  cmd_r, cmd_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0] poll_at_r, poll_at_nxt;

  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    in_fire;

  logic [CW-1:0] poll_int_w;
  logic [CW:0]   poll_sum;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign poll_int_w  = CW'(poll_int_r);

  always_comb begin
    state_nxt    = state_r;
    cfg_done_nxt = cfg_done_r || (in_ch.operation == OP_CONFIG_DONE);
    cmd_nxt      = cmd_r || (in_ch.operation == OP_COMMAND);
    elapsed_nxt  = elapsed_r;
    poll_at_nxt  = poll_at_r;
    poll_sum     = '0;
    res_nxt      = '0;

    if (in_ch.operation == OP_TICK && elapsed_r != TMAX) begin
      elapsed_nxt = elapsed_r + TIMER_BITS'(1);
    end

    case (state_r)
      ST_WAIT_CFG, ST_IDLE, ST_WAIT_CLIENT, ST_WAIT_RESP, ST_FINISH: state_nxt = state_r;
      default: state_nxt = ST_WAIT_CFG;
    endcase

    if (state_nxt == ST_WAIT_CFG) begin
      if (cfg_done_nxt) begin
        res_nxt.configure_strobe = 1'b1;
        state_nxt = ST_IDLE;
      end
    end else begin
      // Idle, pull the line and possibly send, then wait for a response, all
      // in one pass when the thresholds are already met.
      if (state_nxt == ST_IDLE && cmd_nxt) begin
        cmd_nxt     = 1'b0;
        elapsed_nxt = '0;
        state_nxt   = ST_WAIT_CLIENT;
      end
      if (state_nxt == ST_WAIT_CLIENT && CW'(elapsed_nxt) >= CW'(req_wait_r)) begin
        res_nxt.send_strobe = 1'b1;
        elapsed_nxt = '0;
        poll_at_nxt = (poll_int_w > TMAX_W) ? TMAX : poll_int_w[TIMER_BITS-1:0];
        state_nxt   = ST_WAIT_RESP;
      end
      if (state_nxt == ST_WAIT_RESP) begin
        if (CW'(elapsed_nxt) >= CW'(timeout_r)) begin
          res_nxt.event_code = EV_TIMEOUT;
          state_nxt = ST_FINISH;
        end else if (elapsed_nxt >= poll_at_nxt) begin
          res_nxt.poll_strobe = 1'b1;
          poll_sum    = {1'b0, CW'(poll_at_nxt)} + {1'b0, poll_int_w};
          poll_at_nxt = (poll_sum > {1'b0, TMAX_W}) ? TMAX : poll_sum[TIMER_BITS-1:0];
          if (in_ch.reply_length != '0) begin
            res_nxt.event_code = EV_RECEIVED;
            if (in_ch.reply_length > max_len_r) begin
              res_nxt.response_length = max_len_r;
              res_nxt.overflow        = 1'b1;
            end else begin
              res_nxt.response_length = in_ch.reply_length;
            end
            elapsed_nxt = '0;
            state_nxt   = ST_IDLE;
          end
        end
      end else if (state_nxt == ST_FINISH) begin
        state_nxt = ST_IDLE;
      end
    end

    res_nxt.fsm_code         = state_nxt;
    res_nxt.request_line_low = (state_nxt == ST_WAIT_CLIENT) || (state_nxt == ST_WAIT_RESP) ||
                               (state_nxt == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_done_r  <= 1'b0;
      cmd_r       <= 1'b0;
      elapsed_r   <= '0;
      poll_at_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r    <= state_nxt;
        cfg_done_r <= cfg_done_nxt;
        cmd_r      <= cmd_nxt;
        elapsed_r  <= elapsed_nxt;
        poll_at_r  <= poll_at_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_wait_r <= REQUEST_WAIT_RST;
      timeout_r  <= RESPONSE_TIMEOUT_RST;
      poll_int_r <= POLL_INTERVAL_RST;
      max_len_r  <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REQUEST_WAIT:     req_wait_r <= cfg_wdata;
        CFG_RESPONSE_TIMEOUT: timeout_r  <= cfg_wdata;
        CFG_POLL_INTERVAL:    poll_int_r <= cfg_wdata;
        CFG_MAX_LENGTH:       max_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.fsm_code         = res_r.fsm_code;
  assign out_ch.request_line_low = res_r.request_line_low;
  assign out_ch.configure_strobe = res_r.configure_strobe;
  assign out_ch.send_strobe      = res_r.send_strobe;
  assign out_ch.poll_strobe      = res_r.poll_strobe;
  assign out_ch.event_code       = res_r.event_code;
  assign out_ch.overflow         = res_r.overflow;
  assign out_ch.response_length  = res_r.response_length;

  // A clamped length only comes with a received response.
  `HRPS_ASSERT_SAME(a_ovf_only_on_rx, clk, rst_n, out_valid_r && res_r.overflow,
                    res_r.event_code == EV_RECEIVED)
  // A received response releases the line at once and returns to idle.
  `HRPS_ASSERT_SAME(a_rx_releases, clk, rst_n, out_valid_r && res_r.event_code == EV_RECEIVED,
                    !res_r.request_line_low && res_r.fsm_code == ST_IDLE)
  // After sending, the same step ends in wait response, finish or idle.
  `HRPS_ASSERT_SAME(a_send_target, clk, rst_n, out_valid_r && res_r.send_strobe,
                    res_r.fsm_code == ST_WAIT_RESP || res_r.fsm_code == ST_FINISH ||
                    res_r.fsm_code == ST_IDLE)
  // The finish step always leads back to idle.
  `HRPS_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, in_fire && state_r == ST_FINISH,
                    state_r == ST_IDLE)

endmodule

// ===== tb/host_request_poll_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// Request poll sequencer checker
// Watches the input, result and register ports of the sequencer, keeps its own
// copy of the sequencer state and compares every result transfer, field by
// field, with the oldest predicted result. Failures are counted for the top.
// ----------------------------------------------------------------------------
module host_request_poll_sequencer_checker import hrps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  hrps_in_if                    in_ch,
  hrps_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMER_W = TIMER_BITS_DEF;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef enum logic [CODE_W-1:0] {
    SEQ_WAIT_CFG    = 3'd0,
    SEQ_IDLE        = 3'd1,
    SEQ_WAIT_CLIENT = 3'd2,
    SEQ_WAIT_RESP   = 3'd3,
    SEQ_FINISH      = 3'd4
  } seq_state_t;

  logic [MS_W-1:0]    request_wait;
  logic [MS_W-1:0]    response_timeout;
  logic [MS_W-1:0]    poll_interval;
  logic [LEN_W-1:0]   max_length;

  logic [CODE_W-1:0]  seq_state;
  logic               config_seen;
  logic               command_latched;
  logic [TIMER_W-1:0] elapsed;
  logic [TIMER_W-1:0] next_poll;

  result_t due_results[$];

  task automatic report_failure(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // One step of the sequencer: events latch, a tick advances the timer, then
  // the state machine is evaluated once.
  function automatic result_t advance_sequencer(logic [OP_W-1:0] op,
                                                logic [LEN_W-1:0] reply);
    result_t r;
    logic [CODE_W-1:0] st;
    logic [TIMER_W:0] poll_sum;
    r = '0;
    if (op == OP_CONFIG_DONE) config_seen = 1'b1;
    if (op == OP_COMMAND) command_latched = 1'b1;
    if (op == OP_TICK && elapsed != TIMER_MAX) elapsed = elapsed + 1'b1;

    st = seq_state;
    if (st > SEQ_FINISH) st = SEQ_WAIT_CFG;

    if (st == SEQ_WAIT_CFG) begin
      if (config_seen) begin
        r.configure_strobe = 1'b1;
        st = SEQ_IDLE;
      end
    end else begin
      if (st == SEQ_IDLE && command_latched) begin
        command_latched = 1'b0;
        elapsed = '0;
        st = SEQ_WAIT_CLIENT;
      end
      if (st == SEQ_WAIT_CLIENT && elapsed >= request_wait) begin
        r.send_strobe = 1'b1;
        elapsed = '0;
        next_poll = poll_interval;
        st = SEQ_WAIT_RESP;
      end
      if (st == SEQ_WAIT_RESP) begin
        if (elapsed >= response_timeout) begin
          r.event_code = EV_TIMEOUT;
          st = SEQ_FINISH;
        end else if (elapsed >= next_poll) begin
          r.poll_strobe = 1'b1;
          poll_sum = next_poll + poll_interval;
          next_poll = (poll_sum > TIMER_MAX) ? TIMER_MAX : poll_sum[TIMER_W-1:0];
          if (reply != '0) begin
            r.event_code = EV_RECEIVED;
            if (reply > max_length) begin
              r.response_length = max_length;
              r.overflow = 1'b1;
            end else begin
              r.response_length = reply;
            end
            elapsed = '0;
            st = SEQ_IDLE;
          end
        end
      end else if (st == SEQ_FINISH) begin
        st = SEQ_IDLE;
      end
    end

    seq_state = st;
    r.fsm_code = st;
    r.request_line_low = (st == SEQ_WAIT_CLIENT || st == SEQ_WAIT_RESP || st == SEQ_FINISH);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      request_wait = REQUEST_WAIT_RST;
      response_timeout = RESPONSE_TIMEOUT_RST;
      poll_interval = POLL_INTERVAL_RST;
      max_length = MAX_LENGTH_RST;
      seq_state = SEQ_IDLE;
      config_seen = 1'b0;
      command_latched = 1'b0;
      elapsed = '0;
      next_poll = '0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REQUEST_WAIT:     request_wait = cfg_wdata;
          CFG_RESPONSE_TIMEOUT: response_timeout = cfg_wdata;
          CFG_POLL_INTERVAL:    poll_interval = cfg_wdata;
          CFG_MAX_LENGTH:       max_length = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end

      // The result leaving now belongs to an earlier transfer, so compare first.
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_failure("result transfer with no expected result waiting");
        end else begin
          want = due_results.pop_front();
          if (out_ch.fsm_code !== want.fsm_code)
            report_failure($sformatf("fsm_code got %0d want %0d",
                                     out_ch.fsm_code, want.fsm_code));
          if (out_ch.request_line_low !== want.request_line_low)
            report_failure($sformatf("request_line_low got %0b want %0b",
                                     out_ch.request_line_low, want.request_line_low));
          if (out_ch.configure_strobe !== want.configure_strobe)
            report_failure($sformatf("configure_strobe got %0b want %0b",
                                     out_ch.configure_strobe, want.configure_strobe));
          if (out_ch.send_strobe !== want.send_strobe)
            report_failure($sformatf("send_strobe got %0b want %0b",
                                     out_ch.send_strobe, want.send_strobe));
          if (out_ch.poll_strobe !== want.poll_strobe)
            report_failure($sformatf("poll_strobe got %0b want %0b",
                                     out_ch.poll_strobe, want.poll_strobe));
          if (out_ch.event_code !== want.event_code)
            report_failure($sformatf("event_code got %0d want %0d",
                                     out_ch.event_code, want.event_code));
          if (out_ch.overflow !== want.overflow)
            report_failure($sformatf("overflow got %0b want %0b",
                                     out_ch.overflow, want.overflow));
          if (out_ch.response_length !== want.response_length)
            report_failure($sformatf("response_length got %0d want %0d",
                                     out_ch.response_length, want.response_length));
        end
      end

      if (in_ch.valid && in_ch.ready)
        due_results.push_back(advance_sequencer(in_ch.operation, in_ch.reply_length));
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/host_request_poll_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// Request poll sequencer testbench
// Drives operations and client reply bytes into the sequencer under several
// register settings and idling patterns: a random run at the reset values, a
// directed exchange walk, a short run under the largest settings, then random
// phases. The checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module host_request_poll_sequencer_tb import hrps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 150;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fail_count;
  int pending;
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;

  hrps_in_if in_ch ();
  hrps_out_if out_ch ();

  host_request_poll_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  host_request_poll_sequencer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Ends the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      1: begin
        sender_idle_pct = 59;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 59;
      end
      3: begin
        sender_idle_pct = 12;
        receiver_stall_pct = 12;
      end
      default: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endtask

  // Entered and left at a falling edge; valid stays high between back-to-back
  // transfers.
  task automatic push_step(logic [OP_W-1:0] op, logic [LEN_W-1:0] reply);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.reply_length <= reply;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic write_settings(logic [MS_W-1:0] req_wait, logic [MS_W-1:0] timeout,
                                logic [MS_W-1:0] interval, logic [LEN_W-1:0] max_len);
    write_register(CFG_REQUEST_WAIT, req_wait);
    write_register(CFG_RESPONSE_TIMEOUT, timeout);
    write_register(CFG_POLL_INTERVAL, interval);
    write_register(CFG_MAX_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, max_len});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly ticks so that exchanges run through their polls and timeouts;
  // commands are frequent enough to keep the sequencer busy.
  task automatic push_random_step;
    int pick;
    logic [OP_W-1:0] op;
    logic [LEN_W-1:0] reply;
    pick = $urandom_range(0, 99);
    if (pick < 70) op = OP_TICK;
    else if (pick < 83) op = OP_COMMAND;
    else if (pick < 93) op = OP_CONFIG_DONE;
    else op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 55) reply = '0;
    else if (pick < 63) reply = '1;
    else if (pick < 70) reply = 8'd1;
    else reply = LEN_W'($urandom_range(1, 255));
    push_step(op, reply);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.reply_length = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REQUEST_WAIT;
    cfg_wdata = '0;
    rst_n = 1'b0;
    quiet_cycles = 0;
    set_idling(0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values of the registers.
    repeat (120) push_random_step();
    drain();

    // Directed walk: unused operation, repeated events, a command merged while
    // busy, a clamped response, a timeout with its finish step and an exact fit.
    write_settings(16'd2, 16'd6, 16'd2, 8'd10);
    push_step(OP_UNUSED, 8'd255);
    push_step(OP_CONFIG_DONE, 8'd0);
    push_step(OP_CONFIG_DONE, 8'd0);
    push_step(OP_COMMAND, 8'd0);
    push_step(OP_COMMAND, 8'd128);
    push_step(OP_TICK, 8'd0);
    push_step(OP_TICK, 8'd0);
    push_step(OP_TICK, 8'd7);
    push_step(OP_TICK, 8'd0);
    push_step(OP_TICK, 8'd0);
    push_step(OP_TICK, 8'd200);
    push_step(OP_TICK, 8'd0);
    repeat (9) push_step(OP_TICK, 8'd0);
    push_step(OP_COMMAND, 8'd0);
    push_step(OP_TICK, 8'd0);
    push_step(OP_TICK, 8'd0);
    push_step(OP_TICK, 8'd1);
    push_step(OP_TICK, 8'd10);
    drain();

    // Largest settings: a command waits with the line held low.
    write_settings('1, '1, '1, '1);
    push_step(OP_COMMAND, 8'd0);
    repeat (4) push_step(OP_TICK, 8'd0);
    drain();

    for (int phase = 1; phase <= 8; phase++) begin
      case (phase)
        1: write_settings(16'd1, 16'd1, 16'd1, 8'd1);
        2: write_settings(16'd0, 16'd0, 16'd0, 8'd0);
        3: write_settings(MS_W'($urandom_range(0, 3)), MS_W'($urandom_range(8, 30)),
                          MS_W'($urandom_range(1, 5)), 8'd255);
        4: write_settings(16'd2, 16'd60, 16'd0, LEN_W'($urandom_range(1, 254)));
        default: write_settings(MS_W'($urandom_range(0, 6)), MS_W'($urandom_range(0, 50)),
                                MS_W'($urandom_range(0, 10)),
                                LEN_W'($urandom_range(0, 255)));
      endcase
      set_idling(phase % 4);
      repeat (PHASE_ITEMS) push_random_step();
      drain();
    end

    set_idling(0);
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
